// File: rtl/assert_macros.svh
// -----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion shorthands for the escape-time pixel checker.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock, off while reset is low.
`define MBET_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication.
`define MBET_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MBET_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/mbet_pkg.sv
// -----------------------------------------------------------------------------
// mbet_pkg
// Types, constants and helpers shared by the escape-time pixel block.
// -----------------------------------------------------------------------------
`default_nettype none

package mbet_pkg;

  localparam int FRAC_BITS = 28;
  localparam int MAX_DIM   = 1024;

  localparam int COORD_W = 32;
  localparam int PIX_W   = 10;
  localparam int DIM_W   = 11;
  localparam int CNT_W   = 10;
  localparam int COLOR_W = 24;

  // Iteration values stay below 32 in magnitude: sign + 5 integer bits.
  localparam int Z_W     = FRAC_BITS + 6;
  // Magnitudes fed to the multipliers are below 8 (larger ones escape anyway).
  localparam int MAG_W   = FRAC_BITS + 3;
  localparam int SQ_W    = 2 * MAG_W - FRAC_BITS;
  localparam int CROSS_W = SQ_W + 1;
  localparam int ACC_W   = CROSS_W + 1;

  localparam logic [CROSS_W-1:0] ESC_THRESH = CROSS_W'(16) << FRAC_BITS;

  localparam logic [COLOR_W-1:0] COLOR_BASE = 24'h340000;
  localparam logic [COLOR_W-1:0] COLOR_STEP = 24'd10000;

  // Register indexes on the configuration port
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_STEP_X   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_STEP_Y   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_X = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT    = 3'd6;

  typedef struct packed {
    logic [COORD_W-1:0] step_x;
    logic [COORD_W-1:0] step_y;
    logic [COORD_W-1:0] offset_x;
    logic [COORD_W-1:0] offset_y;
    logic [DIM_W-1:0]   frame_width;
    logic [DIM_W-1:0]   frame_height;
    logic [CNT_W-1:0]   iteration_limit;
  } mbet_cfg_t;

  // Controller -> datapath
  typedef struct packed {
    logic capture;   // latch pixel, frame test
    logic map_mul;   // step * (pixel - dim/2)
    logic map_add;   // + offset, saturate, clear z and count
    logic iter_mul;  // squares and cross term of z
    logic iter_step; // z <= z^2 + c, count + 1
    logic emit;      // load result word
  } mbet_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic in_frame;
    logic first;     // no update done yet
    logic escaped;   // |z|^2 > 16 on current z
    logic at_limit;
  } mbet_sts_t;

  function automatic logic [COLOR_W-1:0] mbet_color(input logic [2:0] k);
    return COLOR_BASE - (COLOR_W'(k) * COLOR_STEP);
  endfunction

endpackage

`default_nettype wire

// File: rtl/mbet_ctrl.sv
// -----------------------------------------------------------------------------
// mbet_ctrl
// Sequencer: frame test, then for in-frame pixels mapping and multiply / update steps until escape or limit.
// -----------------------------------------------------------------------------
`default_nettype none

module mbet_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start,
  output logic                busy,
  input  mbet_pkg::mbet_sts_t sts_i,
  output mbet_pkg::mbet_cmd_t cmd_o,
  output logic                done_o
);
  import mbet_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_MAP_MUL  = 3'd1;
  localparam logic [2:0] S_MAP_ADD  = 3'd2;
  localparam logic [2:0] S_ITER_MUL = 3'd3;
  localparam logic [2:0] S_ITER_CHK = 3'd4;

  logic [2:0] state_q, state_d;
  logic       done_q, done_d;

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = S_MAP_MUL;
        end
      end
      S_MAP_MUL: begin
        if (!sts_i.in_frame) begin
          cmd_o.emit = 1'b1;
          done_d     = 1'b1;
          state_d    = S_IDLE;
        end else begin
          cmd_o.map_mul = 1'b1;
          state_d       = S_MAP_ADD;
        end
      end
      S_MAP_ADD: begin
        cmd_o.map_add = 1'b1;
        state_d       = S_ITER_MUL;
      end
      S_ITER_MUL: begin
        cmd_o.iter_mul = 1'b1;
        state_d        = S_ITER_CHK;
      end
      S_ITER_CHK: begin
        if ((!sts_i.first && sts_i.escaped) || sts_i.at_limit) begin
          cmd_o.emit = 1'b1;
          done_d     = 1'b1;
          state_d    = S_IDLE;
        end else begin
          cmd_o.iter_step = 1'b1;
          state_d         = S_ITER_MUL;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

`default_nettype wire

// File: rtl/mbet_datapath.sv
// -----------------------------------------------------------------------------
// mbet_datapath
// Pixel mapping, z^2 + c iteration registers, escape test and result word.
// -----------------------------------------------------------------------------
`default_nettype none

module mbet_datapath (
  input  wire                                  clk_i,
  input  mbet_pkg::mbet_cfg_t                  cfg_i,
  input  mbet_pkg::mbet_cmd_t                  cmd_i,
  output mbet_pkg::mbet_sts_t                  sts_o,
  input  wire  [mbet_pkg::PIX_W-1:0]           pixel_x_i,
  input  wire  [mbet_pkg::PIX_W-1:0]           pixel_y_i,
  output logic [mbet_pkg::COLOR_W-1:0]         pixel_color_o,
  output logic [mbet_pkg::CNT_W-1:0]           escape_count_o,
  output logic                                 in_frame_o
);
  import mbet_pkg::*;

  localparam int PROD_W = COORD_W + DIM_W;
  localparam int SUM_W  = PROD_W + 1;

  function automatic logic [COORD_W-1:0] sat_coord(input logic [SUM_W-1:0] v);
    logic fits;
    fits = (v[SUM_W-1:COORD_W-1] == '0) || (v[SUM_W-1:COORD_W-1] == '1);
    if (fits) begin
      return v[COORD_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

  // frame clamp and test
  logic [DIM_W-1:0] w_eff, h_eff;
  assign w_eff = (cfg_i.frame_width  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg_i.frame_width;
  assign h_eff = (cfg_i.frame_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg_i.frame_height;

  logic [PIX_W-1:0] px_q, py_q;
  logic             in_frame_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      px_q       <= pixel_x_i;
      py_q       <= pixel_y_i;
      in_frame_q <= ({1'b0, pixel_x_i} < w_eff) && ({1'b0, pixel_y_i} < h_eff);
    end
  end

  // mapping: step * (pix - dim/2), then + offset with saturation
  logic signed [DIM_W-1:0]  dx, dy;
  logic signed [PROD_W-1:0] prod_x_q, prod_y_q;
  logic [SUM_W-1:0]         sum_x, sum_y;
  logic signed [COORD_W-1:0] cr_q, ci_q;

  assign dx = $signed({1'b0, px_q}) - $signed({1'b0, w_eff[DIM_W-1:1]});
  assign dy = $signed({1'b0, py_q}) - $signed({1'b0, h_eff[DIM_W-1:1]});

  always_ff @(posedge clk_i) begin
    if (cmd_i.map_mul) begin
      prod_x_q <= $signed(cfg_i.step_x) * dx;
      prod_y_q <= $signed(cfg_i.step_y) * dy;
    end
  end

  assign sum_x = SUM_W'(prod_x_q) + SUM_W'($signed(cfg_i.offset_x));
  assign sum_y = SUM_W'(prod_y_q) + SUM_W'($signed(cfg_i.offset_y));

  always_ff @(posedge clk_i) begin
    if (cmd_i.map_add) begin
      cr_q <= $signed(sat_coord(sum_x));
      ci_q <= $signed(sat_coord(sum_y));
    end
  end

  // iteration state
  logic signed [Z_W-1:0] zr_q, zi_q;
  logic [CNT_W-1:0]      n_q;

  // multiply step: sign/magnitude products, truncated toward zero
  logic [Z_W-1:0]       mag_r, mag_i;
  logic                 big;
  logic [2*MAG_W-1:0]   prod_rr, prod_ii;
  logic [2*MAG_W:0]     prod_ri;
  logic [SQ_W-1:0]      sq_r_q, sq_i_q;
  logic [CROSS_W-1:0]   cross_q;
  logic                 cross_neg_q, big_q;

  assign mag_r   = zr_q[Z_W-1] ? (~zr_q + Z_W'(1)) : zr_q;
  assign mag_i   = zi_q[Z_W-1] ? (~zi_q + Z_W'(1)) : zi_q;
  // a component of 8 or more squares past 16 on its own
  assign big     = (|mag_r[Z_W-1:MAG_W]) || (|mag_i[Z_W-1:MAG_W]);
  assign prod_rr = mag_r[MAG_W-1:0] * mag_r[MAG_W-1:0];
  assign prod_ii = mag_i[MAG_W-1:0] * mag_i[MAG_W-1:0];
  assign prod_ri = {mag_r[MAG_W-1:0], 1'b0} * mag_i[MAG_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.iter_mul) begin
      sq_r_q      <= prod_rr[2*MAG_W-1:FRAC_BITS];
      sq_i_q      <= prod_ii[2*MAG_W-1:FRAC_BITS];
      cross_q     <= prod_ri[2*MAG_W:FRAC_BITS];
      cross_neg_q <= zr_q[Z_W-1] ^ zi_q[Z_W-1];
      big_q       <= big;
    end
  end

  // check / update step
  logic [CROSS_W-1:0]      sum_sq;
  logic                    esc;
  logic signed [ACC_W-1:0] cross_s, nr, ni;

  assign sum_sq  = CROSS_W'(sq_r_q) + CROSS_W'(sq_i_q);
  assign esc     = big_q || (sum_sq > ESC_THRESH);
  assign cross_s = cross_neg_q ? -$signed({1'b0, cross_q}) : $signed({1'b0, cross_q});
  assign nr      = $signed(ACC_W'(sq_r_q)) - $signed(ACC_W'(sq_i_q)) + ACC_W'(cr_q);
  assign ni      = cross_s + ACC_W'(ci_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.map_add) begin
      zr_q <= '0;
      zi_q <= '0;
      n_q  <= '0;
    end else if (cmd_i.iter_step) begin
      zr_q <= nr[Z_W-1:0];
      zi_q <= ni[Z_W-1:0];
      n_q  <= n_q + CNT_W'(1);
    end
  end

  assign sts_o.in_frame = in_frame_q;
  assign sts_o.first    = (n_q == '0);
  assign sts_o.escaped  = esc;
  assign sts_o.at_limit = (n_q == cfg_i.iteration_limit);

  // result word
  logic [CNT_W-1:0] n_m1;
  assign n_m1 = n_q - CNT_W'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (!in_frame_q) begin
        pixel_color_o  <= '0;
        escape_count_o <= '0;
        in_frame_o     <= 1'b0;
      end else if (esc && (n_q != '0)) begin
        pixel_color_o  <= mbet_color(n_m1[2:0]);
        escape_count_o <= n_m1;
        in_frame_o     <= 1'b1;
      end else begin
        pixel_color_o  <= '0;
        escape_count_o <= n_q;
        in_frame_o     <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/mandelbrot_escape_time_pixel.sv
// -----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel
// Escape-time evaluator for one pixel of a Mandelbrot view, Q4.28 coordinates.
// -----------------------------------------------------------------------------
// Usage:
//   Pixel channel: drive pixel_x_i / pixel_y_i and raise start; the word is
//   taken on a rising edge where start is high and busy is low. busy stays
//   high until the result is ready.
//   Result channel: done_o pulses for one cycle with pixel_color_o,
//   escape_count_o and in_frame_o valid. There is no back-pressure; the
//   receiver must take the word in that cycle.
//   Config channel: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
//   ready is always high. Write only while no pixel is in flight.
// Timing:
//   The iteration loop is a multiply step (three 32x32-class multipliers
//   on |zr|, |zi|) followed by an add/compare step for each z update.
//   The next pixel can be taken in the cycle in which done_o shows.
//   Out-of-frame pixels skip the mapping and the iteration loop.
// Reset: rst_ni low clears the sequencer and loads the default view.
// -----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_time_pixel (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  // pixel channel
  input  wire                                   start,
  output logic                                  busy,
  input  wire  [mbet_pkg::PIX_W-1:0]            pixel_x_i,
  input  wire  [mbet_pkg::PIX_W-1:0]            pixel_y_i,
  // result channel
  output logic                                  done_o,
  output logic [mbet_pkg::COLOR_W-1:0]          pixel_color_o,
  output logic [mbet_pkg::CNT_W-1:0]            escape_count_o,
  output logic                                  in_frame_o,
  // config channel
  input  wire                                   cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire  [mbet_pkg::REG_IDX_W-1:0]        cfg_index_i,
  input  wire  [mbet_pkg::COORD_W-1:0]          cfg_data_i
);
  import mbet_pkg::*;

  // Register file. Defaults give a 500x500 view centered on (-0.5, 0).
  mbet_cfg_t cfg_q;
  logic      cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_x          <= COORD_W'(1610613);
      cfg_q.step_y          <= COORD_W'(1073742);
      cfg_q.offset_x        <= COORD_W'(-134217728);
      cfg_q.offset_y        <= '0;
      cfg_q.frame_width     <= DIM_W'(500);
      cfg_q.frame_height    <= DIM_W'(500);
      cfg_q.iteration_limit <= CNT_W'(300);
    end else if (cfg_we) begin
      case (cfg_index_i)
        REG_STEP_X:   cfg_q.step_x          <= cfg_data_i;
        REG_STEP_Y:   cfg_q.step_y          <= cfg_data_i;
        REG_OFFSET_X: cfg_q.offset_x        <= cfg_data_i;
        REG_OFFSET_Y: cfg_q.offset_y        <= cfg_data_i;
        REG_WIDTH:    cfg_q.frame_width     <= cfg_data_i[DIM_W-1:0];
        REG_HEIGHT:   cfg_q.frame_height    <= cfg_data_i[DIM_W-1:0];
        REG_LIMIT:    cfg_q.iteration_limit <= cfg_data_i[CNT_W-1:0];
        default: begin
          // unmapped index: word dropped
        end
      endcase
    end
  end

  mbet_cmd_t cmd;
  mbet_sts_t sts;

  // Sequencer: idle -> map multiply -> map add -> (multiply, check)*; off-frame pixels end at map multiply
  mbet_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .done_o (done_o)
  );

  // Datapath holds c, z, squares, count and the result word
  mbet_datapath u_dp (
    .clk_i          (clk_i),
    .cfg_i          (cfg_q),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .pixel_color_o  (pixel_color_o),
    .escape_count_o (escape_count_o),
    .in_frame_o     (in_frame_o)
  );

endmodule

`default_nettype wire

// File: rtl/mbet_checker.sv
// -----------------------------------------------------------------------------
// mbet_checker
// Port-level checks on the escape-time pixel block, bound to the top level.
// -----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mbet_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        start,
  input wire        busy,
  input wire        done_o,
  input wire [23:0] pixel_color_o,
  input wire [9:0]  escape_count_o,
  input wire        in_frame_o
);

  `MBET_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_o, !busy, "result while busy")
  `MBET_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "accept without busy")
  `MBET_ASSERT_NXT(a_done_single, clk_i, rst_ni, done_o, !done_o, "back-to-back results")
  `MBET_ASSERT_IMP(a_out_zero, clk_i, rst_ni, done_o && !in_frame_o, (pixel_color_o == 24'd0) && (escape_count_o == 10'd0), "out-of-frame word not zero")
  `MBET_ASSERT(a_busy_done, clk_i, rst_ni, !($fell(busy) && done_o && $past(done_o)), "stale result")

endmodule

bind mandelbrot_escape_time_pixel mbet_checker u_mbet_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .done_o         (done_o),
  .pixel_color_o  (pixel_color_o),
  .escape_count_o (escape_count_o),
  .in_frame_o     (in_frame_o)
);

`default_nettype wire

// File: tb/sv/mandelbrot_escape_time_pixel_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_tb
// Self-checking bench for the escape-time pixel evaluator.
// A driver feeds pixel words from a queue and a monitor mirrors the view
// registers. The monitor predicts colour, count and frame flag for every
// accepted pixel and checks them against each done pulse. Directed cases
// come first, then randomized views with random pixel bursts.
// -----------------------------------------------------------------------------

module mandelbrot_escape_time_pixel_tb;

  import mbet_pkg::*;

  // |z|^2 must exceed 16.0 to count as escaped (strict compare)
  localparam longint ESCAPE_LEVEL = 64'sd16 <<< FRAC_BITS;

  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
  } pixel_coord_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [CNT_W-1:0]   count;
    logic               in_frame;
  } escape_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [PIX_W-1:0]     pixel_x_i;
  logic [PIX_W-1:0]     pixel_y_i;
  logic                 done_o;
  logic [COLOR_W-1:0]   pixel_color_o;
  logic [CNT_W-1:0]     escape_count_o;
  logic                 in_frame_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [REG_IDX_W-1:0] cfg_index_i;
  logic [COORD_W-1:0]   cfg_data_i;

  pixel_coord_t   pending_pixels[$];   // words not yet offered to the block
  escape_result_t expected_results[$]; // predictions waiting for done_o
  mbet_cfg_t      view;                // mirror of the view registers
  int unsigned    fault_count;
  bit             sender_idles;        // random start gaps on/off
  int             idle_left;

  mandelbrot_escape_time_pixel dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .done_o         (done_o),
    .pixel_color_o  (pixel_color_o),
    .escape_count_o (escape_count_o),
    .in_frame_o     (in_frame_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Bail out if the run hangs; a clean run needs well under a third of this.
  initial begin
    #12_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Exact signed product, truncated toward zero to FRAC_BITS fraction bits.
  function automatic longint qmul(input longint a, input longint b);
    logic [63:0]  ma;
    logic [63:0]  mb;
    logic [127:0] prod;
    logic [63:0]  mag;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    prod = {64'd0, ma} * {64'd0, mb};
    mag = prod[FRAC_BITS +: 64];
    mag[63:62] = 2'b00;
    return ((a < 0) != (b < 0)) ? -longint'(mag) : longint'(mag);
  endfunction

  // step * (pix - dim/2) + offset, clipped to the signed 32-bit range
  function automatic longint plane_coord(input logic [COORD_W-1:0] step,
                                         input logic [PIX_W-1:0] pix,
                                         input longint dim,
                                         input logic [COORD_W-1:0] offset);
    longint c;
    c = longint'($signed(step)) * (longint'(pix) - (dim >>> 1))
        + longint'($signed(offset));
    if (c > 64'sd2147483647) c = 64'sd2147483647;
    if (c < -64'sd2147483648) c = -64'sd2147483648;
    return c;
  endfunction

  function automatic escape_result_t escape_time_of(input logic [PIX_W-1:0] px,
                                                    input logic [PIX_W-1:0] py);
    escape_result_t r;
    longint w, h, lim, cr, ci, zr, zi, nr, ni, cnt;
    bit escaped;
    r = '0;
    w = (view.frame_width > MAX_DIM) ? MAX_DIM : longint'(view.frame_width);
    h = (view.frame_height > MAX_DIM) ? MAX_DIM : longint'(view.frame_height);
    lim = longint'(view.iteration_limit);
    // outside the frame: all fields zero, no iteration
    if (longint'(px) >= w || longint'(py) >= h) return r;
    cr = plane_coord(view.step_x, px, w, view.offset_x);
    ci = plane_coord(view.step_y, py, h, view.offset_y);
    zr = 0;
    zi = 0;
    cnt = 0;
    escaped = 1'b0;
    while (cnt < lim && !escaped) begin
      nr = qmul(zr, zr) - qmul(zi, zi) + cr;
      ni = qmul(2 * zr, zi) + ci;
      zr = nr;
      zi = ni;
      if (qmul(zr, zr) + qmul(zi, zi) > ESCAPE_LEVEL) escaped = 1'b1;
      else cnt++;
    end
    // points that ran out the limit (limit 0 included) stay black
    if (cnt < lim) r.color = COLOR_BASE - COLOR_STEP * COLOR_W'(cnt % 8);
    r.count = CNT_W'(cnt);
    r.in_frame = 1'b1;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Pixel driver: holds start until the word is taken, idles in bursts
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive_pixels
    pixel_coord_t nxt;
    if (!rst_ni) begin
      start <= 1'b0;
      pixel_x_i <= '0;
      pixel_y_i <= '0;
      idle_left = 0;
    end else if (!start || !busy) begin
      // slot free: previous word taken, or nothing offered
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
        pixel_x_i <= PIX_W'($urandom);
        pixel_y_i <= PIX_W'($urandom);
      end else if (pending_pixels.size() != 0 && sender_idles &&
                   $urandom_range(0, 3) == 0) begin
        idle_left = $urandom_range(0, 5);
        start <= 1'b0;
        pixel_x_i <= PIX_W'($urandom);
        pixel_y_i <= PIX_W'($urandom);
      end else if (pending_pixels.size() != 0) begin
        nxt = pending_pixels.pop_front();
        start <= 1'b1;
        pixel_x_i <= nxt.x;
        pixel_y_i <= nxt.y;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: mirrors config writes, predicts on accept, checks on done
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fault_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch_results
    escape_result_t want;
    if (!rst_ni) begin
      view.step_x          = 32'd1610613;
      view.step_y          = 32'd1073742;
      view.offset_x        = 32'hF800_0000; // -0.5
      view.offset_y        = 32'd0;
      view.frame_width     = 11'd500;
      view.frame_height    = 11'd500;
      view.iteration_limit = 10'd300;
      expected_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_STEP_X:   view.step_x = cfg_data_i;
          REG_STEP_Y:   view.step_y = cfg_data_i;
          REG_OFFSET_X: view.offset_x = cfg_data_i;
          REG_OFFSET_Y: view.offset_y = cfg_data_i;
          REG_WIDTH:    view.frame_width = cfg_data_i[DIM_W-1:0];
          REG_HEIGHT:   view.frame_height = cfg_data_i[DIM_W-1:0];
          REG_LIMIT:    view.iteration_limit = cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end
      // result first: a new word may be taken in the done cycle
      if (done_o) begin
        if (expected_results.size() == 0) begin
          if (fault_count < 40) $error("done_o with no pixel outstanding");
          fault_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("pixel_color", 32'(want.color), 32'(pixel_color_o));
          check_field("escape_count", 32'(want.count), 32'(escape_count_o));
          check_field("in_frame", 32'(want.in_frame), 32'(in_frame_o));
        end
      end
      if (start && !busy) expected_results.push_back(escape_time_of(pixel_x_i, pixel_y_i));
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic queue_pixel(input int unsigned x, input int unsigned y);
    pending_pixels.push_back('{x: PIX_W'(x), y: PIX_W'(y)});
  endtask

  // Block until every queued word is taken and answered and the block is idle.
  // Sampled mid-cycle so the driver and monitor updates of the edge are seen.
  task automatic drain();
    do @(negedge clk_i);
    while (pending_pixels.size() != 0 || start || expected_results.size() != 0 || busy);
  endtask

  initial begin : stimulus
    int unsigned w, h, eff_w, eff_h, lim, zoom, n;
    logic [31:0] sx, sy, ox, oy;
    rst_ni       <= 1'b0;
    cfg_valid_i  <= 1'b0;
    cfg_index_i  <= REG_STEP_X;
    cfg_data_i   <= '0;
    fault_count  = 0;
    sender_idles = 1'b1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // --- reset view: 500x500, centre -0.5+0i, limit 300 ---
    queue_pixel(250, 250);   // c = -0.5, never escapes
    queue_pixel(0, 0);       // far corner, fast escape
    queue_pixel(499, 499);   // last pixel in frame
    queue_pixel(499, 0);
    queue_pixel(0, 499);
    queue_pixel(125, 250);   // c = -1.25, edge of the period-2 bulb
    queue_pixel(300, 180);
    queue_pixel(500, 7);     // one column past the frame
    queue_pixel(7, 500);     // one row past the frame
    queue_pixel(1023, 1023); // all ones, off frame
    drain();

    // zero limit: no iteration, black, count 0
    write_reg(REG_LIMIT, 32'd0);
    queue_pixel(250, 250);
    drain();
    write_reg(REG_LIMIT, 32'd1);
    queue_pixel(250, 250);
    queue_pixel(0, 0);
    drain();

    // zero width, then oversized width clipped to MAX_DIM
    write_reg(REG_WIDTH, 32'd0);
    write_reg(REG_HEIGHT, 32'd2047);
    queue_pixel(0, 0);
    queue_pixel(3, 1023);
    drain();
    write_reg(REG_WIDTH, 32'd2047);
    write_reg(REG_HEIGHT, 32'd1);
    queue_pixel(1023, 0);
    queue_pixel(0, 1);
    drain();

    // coordinate saturation at both rails
    write_reg(REG_WIDTH, 32'd1024);
    write_reg(REG_HEIGHT, 32'd1024);
    write_reg(REG_STEP_X, 32'h7FFF_FFFF);
    write_reg(REG_STEP_Y, 32'h7FFF_FFFF);
    write_reg(REG_OFFSET_X, 32'h7FFF_FFFF);
    write_reg(REG_OFFSET_Y, 32'h8000_0000);
    write_reg(REG_LIMIT, 32'd5);
    queue_pixel(1023, 1023);
    queue_pixel(0, 0);
    queue_pixel(512, 512);   // lands exactly on the offsets
    drain();
    write_reg(REG_STEP_X, 32'h8000_0000);
    write_reg(REG_STEP_Y, 32'h8000_0000);
    queue_pixel(1023, 0);
    drain();

    // fixed c: origin never escapes, c = 4 lands exactly on the threshold before
    // it escapes, c = -2 settles at |z|^2 = 4 and never escapes
    write_reg(REG_STEP_X, 32'd0);
    write_reg(REG_STEP_Y, 32'd0);
    write_reg(REG_OFFSET_X, 32'd0);
    write_reg(REG_OFFSET_Y, 32'd0);
    write_reg(REG_LIMIT, 32'd1023);
    queue_pixel(5, 5);
    drain();
    write_reg(REG_OFFSET_X, 32'h4000_0000);
    queue_pixel(5, 5);
    drain();
    write_reg(REG_OFFSET_X, 32'hE000_0000);
    queue_pixel(5, 5);
    drain();

    // --- random views: mostly plausible zoom/pan, some raw register noise ---
    for (int p = 0; p < 10; p++) begin
      sender_idles = (p < 8);
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(1025, 2047) : $urandom_range(1, 1024);
      h = ($urandom_range(0, 7) == 0) ? $urandom_range(1025, 2047) : $urandom_range(1, 1024);
      eff_w = (w > MAX_DIM) ? MAX_DIM : w;
      eff_h = (h > MAX_DIM) ? MAX_DIM : h;
      // keep most phases cheap; one at the default limit, one at the maximum
      lim = (p == 3) ? 300 : (p == 6) ? 1023 :
            (p == 8) ? $urandom_range(0, 15) : $urandom_range(1, 64);
      zoom = $urandom_range(1, 64);
      sx = ($urandom_range(0, 5) == 0) ? $urandom : (32'h3000_0000 / eff_w) / zoom;
      sy = ($urandom_range(0, 5) == 0) ? $urandom : (32'h2000_0000 / eff_h) / zoom;
      ox = ($urandom_range(0, 5) == 0) ? $urandom
           : $urandom_range(0, 32'h3000_0000) - 32'h2000_0000;  // -2.0 .. 1.0
      oy = ($urandom_range(0, 5) == 0) ? $urandom
           : $urandom_range(0, 32'h3000_0000) - 32'h1800_0000;  // -1.5 .. 1.5
      write_reg(REG_STEP_X, sx);
      write_reg(REG_STEP_Y, sy);
      write_reg(REG_OFFSET_X, ox);
      write_reg(REG_OFFSET_Y, oy);
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
      write_reg(REG_LIMIT, lim);
      n = (p == 6) ? 24 : 140;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 7) == 0) queue_pixel($urandom, $urandom);
        else queue_pixel($urandom_range(0, eff_w - 1), $urandom_range(0, eff_h - 1));
      end
      drain();
    end

    // catch any stray done pulse after the last word
    repeat (2100) @(posedge clk_i);
    if (fault_count == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
